// ===== design/mtep_pkg.sv =====
// Package for the track event parser: item types, parse phases and
// status nibble codes. No dependencies.
package mtep_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        note_valid;
    logic [1:0]  event_kind;
    logic [3:0]  channel;
    logic [7:0]  program_res;
    logic [7:0]  note_number;
    logic [7:0]  velocity;
    logic [31:0] delta_ticks;
    logic        end_of_track;
    logic        truncated;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_DELTA     = 3'd0,
    PH_STATUS    = 3'd1,
    PH_DATA1     = 3'd2,
    PH_DATA2     = 3'd3,
    PH_PROG      = 3'd4,
    PH_SKIP      = 3'd5,
    PH_META_TYPE = 3'd6,
    PH_LEN       = 3'd7
  } phase_e;

  // High nibbles of status bytes.
  localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
  localparam logic [3:0] ST_NOTE_ON   = 4'h9;
  localparam logic [3:0] ST_POLY_PRES = 4'hA;
  localparam logic [3:0] ST_CONTROL   = 4'hB;
  localparam logic [3:0] ST_PROGRAM   = 4'hC;
  localparam logic [3:0] ST_CHAN_PRES = 4'hD;
  localparam logic [3:0] ST_BEND      = 4'hE;
  localparam logic [3:0] ST_SYSTEM    = 4'hF;

  localparam logic [7:0] META_STATUS  = 8'hFF;
  localparam logic [7:0] NO_STATUS    = 8'h00;

endpackage

// ===== design/mtep_core.sv =====
// Parser state and the next-state logic for one byte.
// Depends on mtep_pkg.
module mtep_core #(
  parameter int DELTA_SUM_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  mtep_pkg::in_item_t item_i,
  output logic               res_valid_o,
  output mtep_pkg::out_item_t res_o
);

  localparam int SW = DELTA_SUM_WIDTH;
  localparam int XW = (SW > 32) ? SW : 32;

  mtep_pkg::phase_e phase_q, phase_d;
  logic [27:0]   accum_q, accum_d;
  logic [1:0]    groups_q, groups_d;
  logic [SW-1:0] total_q, total_d;
  logic [7:0]    status_q, status_d;
  logic [7:0]    program_q, program_d;
  logic [7:0]    first_q, first_d;
  logic [7:0]    skip_q, skip_d;

  logic [7:0]    b;
  logic [3:0]    hi;
  logic [3:0]    rs_hi;
  logic [27:0]   accum_shift;
  logic [SW:0]   sum_wide;
  logic [SW-1:0] sum_sat;
  logic          note;
  logic [SW-1:0] ticks;
  logic [XW-1:0] ticks_ext;
  logic [7:0]    skip_dec;

  assign b           = item_i.data_byte;
  assign hi          = b[7:4];
  assign rs_hi       = status_q[7:4];
  assign accum_shift = {accum_q[20:0], b[6:0]};
  assign sum_wide    = {1'b0, total_q} + (SW+1)'(accum_shift);
  assign sum_sat     = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
  assign skip_dec    = (skip_q != 8'd0) ? skip_q - 8'd1 : skip_q;

  always_comb begin
    phase_d   = phase_q;
    accum_d   = accum_q;
    groups_d  = groups_q;
    total_d   = total_q;
    status_d  = status_q;
    program_d = program_q;
    first_d   = first_q;
    skip_d    = skip_q;
    note      = 1'b0;
    case (phase_q)
      mtep_pkg::PH_DELTA: begin
        accum_d  = accum_shift;
        groups_d = groups_q + 2'd1;
        // The fourth group ends the delta whatever its top bit is.
        if (!b[7] || groups_q == 2'd3) begin
          total_d  = sum_sat;
          accum_d  = '0;
          groups_d = '0;
          phase_d  = mtep_pkg::PH_STATUS;
        end
      end
      mtep_pkg::PH_STATUS: begin
        if (b[7]) begin
          if (hi == mtep_pkg::ST_SYSTEM) begin
            status_d = mtep_pkg::NO_STATUS;
            phase_d  = (b == mtep_pkg::META_STATUS) ? mtep_pkg::PH_META_TYPE
                                                    : mtep_pkg::PH_LEN;
          end else begin
            status_d = b;
            if (hi inside {mtep_pkg::ST_NOTE_OFF, mtep_pkg::ST_NOTE_ON,
                           mtep_pkg::ST_POLY_PRES}) begin
              phase_d = mtep_pkg::PH_DATA1;
            end else if (hi == mtep_pkg::ST_PROGRAM) begin
              phase_d = mtep_pkg::PH_PROG;
            end else begin
              skip_d  = (hi == mtep_pkg::ST_CHAN_PRES) ? 8'd1 : 8'd2;
              phase_d = mtep_pkg::PH_SKIP;
            end
          end
        end else if (status_q[7] && rs_hi != mtep_pkg::ST_SYSTEM) begin
          // Running status: this byte is the first data byte.
          if (rs_hi inside {mtep_pkg::ST_NOTE_OFF, mtep_pkg::ST_NOTE_ON,
                            mtep_pkg::ST_POLY_PRES}) begin
            first_d = b;
            phase_d = mtep_pkg::PH_DATA2;
          end else if (rs_hi inside {mtep_pkg::ST_CONTROL, mtep_pkg::ST_BEND}) begin
            skip_d  = 8'd1;
            phase_d = mtep_pkg::PH_SKIP;
          end else if (rs_hi == mtep_pkg::ST_PROGRAM) begin
            program_d = b;
            phase_d   = mtep_pkg::PH_DELTA;
          end else begin
            phase_d = mtep_pkg::PH_DELTA;
          end
        end
      end
      mtep_pkg::PH_DATA1: begin
        first_d = b;
        phase_d = mtep_pkg::PH_DATA2;
      end
      mtep_pkg::PH_DATA2: begin
        note    = 1'b1;
        total_d = '0;
        phase_d = mtep_pkg::PH_DELTA;
      end
      mtep_pkg::PH_PROG: begin
        program_d = b;
        phase_d   = mtep_pkg::PH_DELTA;
      end
      mtep_pkg::PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 8'd0) phase_d = mtep_pkg::PH_DELTA;
      end
      mtep_pkg::PH_META_TYPE: begin
        phase_d = mtep_pkg::PH_LEN;
      end
      mtep_pkg::PH_LEN: begin
        skip_d  = b;
        phase_d = (b == 8'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
      end
      default: begin
        phase_d = mtep_pkg::PH_DELTA;
      end
    endcase
  end

  assign ticks     = note ? total_q : total_d;
  assign ticks_ext = XW'(ticks);

  always_comb begin
    res_valid_o        = note || item_i.last_byte;
    res_o.note_valid   = note;
    res_o.event_kind   = note ? status_q[5:4] : 2'd0;
    res_o.channel      = note ? status_q[3:0] : 4'd0;
    res_o.program_res  = program_d;
    res_o.note_number  = note ? first_q : 8'd0;
    res_o.velocity     = note ? b : 8'd0;
    res_o.delta_ticks  = ticks_ext[31:0];
    res_o.end_of_track = item_i.last_byte;
    res_o.truncated    = item_i.last_byte &&
                         (phase_d != mtep_pkg::PH_DELTA || groups_d != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mtep_pkg::PH_DELTA;
      accum_q   <= '0;
      groups_q  <= '0;
      total_q   <= '0;
      status_q  <= mtep_pkg::NO_STATUS;
      program_q <= '0;
      first_q   <= '0;
      skip_q    <= '0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        // The last byte returns everything to the start of a fresh track.
        phase_q   <= mtep_pkg::PH_DELTA;
        accum_q   <= '0;
        groups_q  <= '0;
        total_q   <= '0;
        status_q  <= mtep_pkg::NO_STATUS;
        program_q <= '0;
        first_q   <= '0;
        skip_q    <= '0;
      end else begin
        phase_q   <= phase_d;
        accum_q   <= accum_d;
        groups_q  <= groups_d;
        total_q   <= total_d;
        status_q  <= status_d;
        program_q <= program_d;
        first_q   <= first_d;
        skip_q    <= skip_d;
      end
    end
  end

endmodule

// ===== design/midi_track_event_parser.sv =====
// Top level of the track event parser: input register, parser core and
// result register. Depends on mtep_pkg and mtep_core.
//
// Usage: the input channel carries one track payload byte per item, with
// last_byte set on the final byte of a track. The output channel carries a
// result item for each completed note off, note on or polyphonic pressure
// event and for the last byte of a track (end_of_track set, truncated set
// when the track ended inside a delta time or an event). Bytes that finish
// nothing produce no result item.
// A byte accepted into the input register is parsed by the core on its way
// into the result register, which drives the output channel.
// Throughput is one byte per cycle while the receiver does not stall: the
// byte in the input register is parsed by the core and its result is written
// into the result register at the same edge at which the next byte is taken.
// When the receiver stalls, the result register holds its item and the
// input register holds one more byte; the input side stalls only while both
// are full. Bytes that give no result still pass through the input register
// and are parsed as soon as the result register can move.
// Reset empties both registers and puts the parser at the start of a delta
// time with no running status, program zero and an empty tick sum.
module midi_track_event_parser #(
  parameter int DELTA_SUM_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mtep_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mtep_pkg::out_item_t  out_item_o
);

  logic                in_valid_q;
  mtep_pkg::in_item_t  in_q;
  logic                out_valid_q;
  mtep_pkg::out_item_t out_q;
  logic                advance;
  logic                step;
  logic                in_ready;
  logic                res_valid;
  mtep_pkg::out_item_t res;

  // The result register can take a new value when it is empty or drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_ready   = !in_valid_q || step;
  assign in_stall_o = !in_ready;

  mtep_core #(
    .DELTA_SUM_WIDTH(DELTA_SUM_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled while the pipeline could move");

  a_truncated_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.truncated) |-> out_item_o.end_of_track)
    else $error("truncated flag without end of track");

  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.note_valid || out_item_o.end_of_track))
    else $error("result item with neither a note nor an end of track");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.note_valid) |-> (out_item_o.event_kind != 2'd3))
    else $error("note result with an impossible event kind");

  a_result_follows_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(step && res_valid))
    else $error("result appeared without a parsed byte");
`endif

endmodule

// ===== dv/midi_track_event_parser_tb.sv =====
// Self-checking testbench for midi_track_event_parser: a directed table of track bytes, then
// random well-formed tracks mixed with noise, results checked against typed rows or a local parser model.
// Depends on mtep_pkg and the midi_track_event_parser RTL.
module midi_track_event_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtep_pkg::*;

  localparam int          SUM_W        = 32;
  localparam logic [63:0] TICK_MAX     = (64'd1 << SUM_W) - 64'd1;
  localparam int          RANDOM_BYTES = 1250;
  localparam int          HOLD_CYCLES  = 150;
  localparam int          IDLE_LIMIT   = 1000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          MAX_REPORTS  = 10;

  // Event kinds as they appear in a result item.
  localparam logic [1:0] KIND_NOTE_OFF = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [1:0] KIND_POLY     = 2'd2;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_item_t   in_item_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_item_o;

  midi_track_event_parser #(
    .DELTA_SUM_WIDTH(SUM_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Parser model. It keeps its own copy of the track state and is stepped once
  // for every byte that the block accepts.
  // ---------------------------------------------------------------------------
  phase_e      ph;
  logic [27:0] vlq_acc;
  logic [2:0]  vlq_cnt;
  logic [63:0] tick_sum;
  logic [7:0]  run_status;
  logic [7:0]  cur_prog;
  logic [7:0]  note_key;
  logic [7:0]  bytes_left;

  function automatic void clear_parser();
    ph         = PH_DELTA;
    vlq_acc    = '0;
    vlq_cnt    = '0;
    tick_sum   = '0;
    run_status = NO_STATUS;
    cur_prog   = '0;
    note_key   = '0;
    bytes_left = '0;
  endfunction

  // Consumes one track byte. Returns 1 when the byte yields a result item.
  function automatic bit parse_byte(input in_item_t it, output out_item_t res);
    logic [7:0]  b;
    logic [3:0]  hi;
    logic [63:0] sent;
    bit          got_note;
    b        = it.data_byte;
    hi       = b[7:4];
    sent     = '0;
    got_note = 1'b0;
    res      = '0;
    case (ph)
      PH_DELTA: begin
        vlq_acc = {vlq_acc[20:0], b[6:0]};
        vlq_cnt = vlq_cnt + 3'd1;
        // The fourth group closes the delta whatever its top bit says.
        if (!b[7] || vlq_cnt >= 3'd4) begin
          if (tick_sum > TICK_MAX || {36'd0, vlq_acc} > TICK_MAX - tick_sum) begin
            tick_sum = TICK_MAX;
          end else begin
            tick_sum = tick_sum + {36'd0, vlq_acc};
          end
          vlq_acc = '0;
          vlq_cnt = '0;
          ph      = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b[7]) begin
          if (hi == ST_SYSTEM) begin
            run_status = NO_STATUS;
            ph = (b == META_STATUS) ? PH_META_TYPE : PH_LEN;
          end else begin
            run_status = b;
            case (hi)
              ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRES: ph = PH_DATA1;
              ST_PROGRAM: ph = PH_PROG;
              default: begin
                bytes_left = (hi == ST_CHAN_PRES) ? 8'd1 : 8'd2;
                ph         = PH_SKIP;
              end
            endcase
          end
        end else if (run_status[7] && run_status[7:4] != ST_SYSTEM) begin
          // Running status: this byte is the first data byte of the message.
          case (run_status[7:4])
            ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRES: begin
              note_key = b;
              ph       = PH_DATA2;
            end
            ST_CONTROL, ST_BEND: begin
              bytes_left = 8'd1;
              ph         = PH_SKIP;
            end
            ST_PROGRAM: begin
              cur_prog = b;
              ph       = PH_DELTA;
            end
            default: ph = PH_DELTA;
          endcase
        end
        // A data byte with no channel status is dropped.
      end
      PH_DATA1: begin
        note_key = b;
        ph       = PH_DATA2;
      end
      PH_DATA2: begin
        got_note        = 1'b1;
        res.event_kind  = run_status[5:4];
        res.channel     = run_status[3:0];
        res.note_number = note_key;
        res.velocity    = b;
        sent            = tick_sum;
        tick_sum        = '0;
        ph              = PH_DELTA;
      end
      PH_PROG: begin
        cur_prog = b;
        ph       = PH_DELTA;
      end
      PH_SKIP: begin
        if (bytes_left != 8'd0) bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) ph = PH_DELTA;
      end
      PH_META_TYPE: ph = PH_LEN;
      PH_LEN: begin
        bytes_left = b;
        ph = (b == 8'd0) ? PH_DELTA : PH_SKIP;
      end
      default: ph = PH_DELTA;
    endcase

    if (!got_note && !it.last_byte) return 1'b0;

    res.note_valid  = got_note;
    res.program_res = cur_prog;
    res.delta_ticks = got_note ? sent[31:0] : tick_sum[31:0];
    if (it.last_byte) begin
      res.end_of_track = 1'b1;
      res.truncated    = (ph != PH_DELTA) || (vlq_cnt != 3'd0);
      clear_parser();
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus storage.
  // ---------------------------------------------------------------------------
  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } track_row_t;

  track_row_t dir_rows[$];
  in_item_t   stim_q[$];
  out_item_t  pending_q[$];

  int unsigned mismatches     = 0;
  bit          random_started = 1'b0;
  bit          hold_done      = 1'b0;

  function automatic out_item_t mk_res(input logic note, input logic [1:0] kind,
                                       input logic [3:0] ch, input logic [7:0] prog,
                                       input logic [7:0] nn, input logic [7:0] vel,
                                       input logic [31:0] ticks, input logic eot,
                                       input logic trunc);
    out_item_t r;
    r.note_valid   = note;
    r.event_kind   = kind;
    r.channel      = ch;
    r.program_res  = prog;
    r.note_number  = nn;
    r.velocity     = vel;
    r.delta_ticks  = ticks;
    r.end_of_track = eot;
    r.truncated    = trunc;
    return r;
  endfunction

  task automatic add_row(input logic [7:0] b, input logic last);
    track_row_t row;
    row.it    = '{data_byte: b, last_byte: last};
    row.typed = 1'b0;
    row.want  = '0;
    dir_rows.push_back(row);
  endtask

  task automatic add_typed(input logic [7:0] b, input logic last, input out_item_t want);
    track_row_t row;
    row.it    = '{data_byte: b, last_byte: last};
    row.typed = 1'b1;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  task automatic push_byte(input logic [7:0] b);
    stim_q.push_back('{data_byte: b, last_byte: 1'b0});
  endtask

  // Data bytes are mostly proper 7-bit values, but a quarter of them are drawn
  // from the full byte range so that status-valued data inside a message gets exercised.
  function automatic logic [7:0] rand_data();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 127));
  endfunction

  // Idle lengths: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic set_last(input int unsigned idx);
    in_item_t tmp;
    tmp           = stim_q[idx];
    tmp.last_byte = 1'b1;
    stim_q[idx]   = tmp;
  endtask

  // Builds random tracks: mostly a delta time followed by a complete event,
  // with the odd noise byte, saturating run of long deltas, and track ends
  // that fall either cleanly after an event or in the middle of one.
  task automatic build_random_stream(input int unsigned target);
    int unsigned start, r, n, len;
    logic [7:0]  b;
    logic [3:0]  note_ops [3];
    note_ops = '{ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRES};
    while (stim_q.size() < target) begin
      start = stim_q.size();
      if ($urandom_range(0, 99) == 0) begin
        // Twenty maximal deltas drive the tick sum into saturation.
        repeat (20) begin
          repeat (4) push_byte(8'hFF);
          push_byte({ST_CONTROL, 4'($urandom_range(0, 15))});
          push_byte(rand_data());
          push_byte(rand_data());
        end
      end

      r = $urandom_range(0, 99);
      n = (r < 70) ? 1 : (r < 85) ? 2 : (r < 95) ? 3 : 4;
      for (int unsigned i = 0; i < n; i++) begin
        b = 8'($urandom_range(0, 127));
        if (i + 1 < n || (n == 4 && $urandom_range(0, 1) == 1)) b[7] = 1'b1;
        push_byte(b);
      end

      r = $urandom_range(0, 99);
      if (r < 40) begin
        push_byte({note_ops[$urandom_range(0, 2)], 4'($urandom_range(0, 15))});
        push_byte(rand_data());
        push_byte(rand_data());
      end else if (r < 52) begin
        push_byte(8'($urandom_range(0, 127)));
        push_byte(rand_data());
      end else if (r < 60) begin
        push_byte({ST_PROGRAM, 4'($urandom_range(0, 15))});
        push_byte(rand_data());
      end else if (r < 68) begin
        push_byte({ST_CONTROL, 4'($urandom_range(0, 15))});
        push_byte(rand_data());
        push_byte(rand_data());
      end else if (r < 73) begin
        push_byte({ST_CHAN_PRES, 4'($urandom_range(0, 15))});
        push_byte(rand_data());
      end else if (r < 78) begin
        push_byte({ST_BEND, 4'($urandom_range(0, 15))});
        push_byte(rand_data());
        push_byte(rand_data());
      end else if (r < 90) begin
        if (r < 85) begin
          push_byte(META_STATUS);
          push_byte(8'($urandom_range(0, 255)));
        end else begin
          push_byte({ST_SYSTEM, 4'($urandom_range(0, 14))});
        end
        len = ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(0, 4);
        push_byte(8'(len));
        repeat (len) push_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
      end

      if ($urandom_range(0, 14) == 0) begin
        set_last(stim_q.size() - 1);
      end else if ($urandom_range(0, 59) == 0) begin
        set_last($urandom_range(start, stim_q.size() - 1));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side. The item is presented at a falling edge and held until a
  // rising edge sees valid high with stall low. The model is stepped at that
  // edge, so the expected result is queued before the block delivers it.
  // ---------------------------------------------------------------------------
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    int unsigned gap;
    out_item_t   res;
    bit          got;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      in_item_i  <= in_item_t'($urandom_range(0, 511));
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    got = parse_byte(it, res);
    if (typed) begin
      pending_q.push_back(want);
    end else if (got) begin
      pending_q.push_back(res);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side. Stall comes in random stretches. Once the random part has
  // begun, a single long hold lets the result register and the input
  // register fill so that the block has to stall its own input.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (random_started && !hold_done) begin
        hold_done = 1'b1;
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end
      n = idle_len();
      if (n > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end
      n = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 8);
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  end

  function automatic string fmt_res(input out_item_t r);
    return $sformatf("nv=%0b kind=%0d ch=%0d prog=%02h nn=%02h vel=%02h ticks=%08h eot=%0b tr=%0b",
                     r.note_valid, r.event_kind, r.channel, r.program_res, r.note_number,
                     r.velocity, r.delta_ticks, r.end_of_track, r.truncated);
  endfunction

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    bit        bad;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result at %0t: %s", $realtime, fmt_res(out_item_o));
        end
      end else begin
        want = pending_q.pop_front();
        bad  = (out_item_o.note_valid   !== want.note_valid)   ||
               (out_item_o.event_kind   !== want.event_kind)   ||
               (out_item_o.channel      !== want.channel)      ||
               (out_item_o.program_res  !== want.program_res)  ||
               (out_item_o.note_number  !== want.note_number)  ||
               (out_item_o.velocity     !== want.velocity)     ||
               (out_item_o.delta_ticks  !== want.delta_ticks)  ||
               (out_item_o.end_of_track !== want.end_of_track) ||
               (out_item_o.truncated    !== want.truncated);
        if (bad) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch at %0t\n  expected %s\n  actual   %s", $realtime,
                     fmt_res(want), fmt_res(out_item_o));
          end
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with no item moving on either side.
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    clear_parser();

    // Note on, channel 0, lowest note number: the first result after reset.
    add_row(8'h00, 1'b0);
    add_row({ST_NOTE_ON, 4'h0}, 1'b0);
    add_row(8'h00, 1'b0);
    add_typed(8'h7F, 1'b0,
              mk_res(1'b1, KIND_NOTE_ON, 4'h0, 8'h00, 8'h00, 8'h7F, 32'h0, 1'b0, 1'b0));
    // A four-group delta whose last group still has its top bit set, then a
    // note off on channel 15 whose data bytes look like status bytes.
    repeat (4) add_row(8'hFF, 1'b0);
    add_row({ST_NOTE_OFF, 4'hF}, 1'b0);
    add_row(8'hFF, 1'b0);
    add_typed(8'hFF, 1'b0,
              mk_res(1'b1, KIND_NOTE_OFF, 4'hF, 8'h00, 8'hFF, 8'hFF, 32'h0FFF_FFFF,
                     1'b0, 1'b0));
    // Running status: a data byte right after the delta continues the note off.
    add_row(8'h00, 1'b0);
    add_row(8'h40, 1'b0);
    add_row(8'h01, 1'b0);
    // Program change.
    add_row(8'h00, 1'b0);
    add_row({ST_PROGRAM, 4'hA}, 1'b0);
    add_row(8'h55, 1'b0);
    // Controller, channel pressure and pitch bend are consumed silently.
    add_row(8'h00, 1'b0);
    add_row({ST_CONTROL, 4'h1}, 1'b0);
    add_row(8'h07, 1'b0);
    add_row(8'h64, 1'b0);
    add_row(8'h00, 1'b0);
    add_row({ST_CHAN_PRES, 4'h2}, 1'b0);
    add_row(8'h10, 1'b0);
    add_row(8'h00, 1'b0);
    add_row({ST_BEND, 4'h4}, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h40, 1'b0);
    // Meta event with a zero length, then a system message with one byte.
    add_row(8'h00, 1'b0);
    add_row(META_STATUS, 1'b0);
    add_row(8'h2F, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row({ST_SYSTEM, 4'h0}, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'hAA, 1'b0);
    // The system message cleared running status, so this data byte is
    // dropped; the polyphonic pressure that follows still parses.
    add_row(8'h00, 1'b0);
    add_row(8'h12, 1'b0);
    add_row({ST_POLY_PRES, 4'h3}, 1'b0);
    add_row(8'h20, 1'b0);
    add_row(8'h30, 1'b0);
    // Track ends inside a delta time: end-of-track result flagged truncated.
    add_typed(8'h81, 1'b1,
              mk_res(1'b0, KIND_NOTE_OFF, 4'h0, 8'h55, 8'h00, 8'h00, 32'h0, 1'b1, 1'b1));
    // A fresh track whose last byte completes a note: a clean end.
    add_row(8'h00, 1'b0);
    add_row({ST_NOTE_ON, 4'h5}, 1'b0);
    add_row(8'h3C, 1'b0);
    add_row(8'h40, 1'b1);

    build_random_stream(RANDOM_BYTES);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    random_started = 1'b1;
    foreach (stim_q[i]) send_item(stim_q[i], 1'b0, '0);
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mtep_pkg.sv
design/mtep_core.sv
design/midi_track_event_parser.sv
dv/midi_track_event_parser_tb.sv
